// ===== src/lap_pkg.sv =====
// Shared constants, register codes, rounding and saturation helpers of the lattice ADPCM decoder.
package lap_pkg;

	// lattice order default
	localparam int ORDER_DEF = 8;

	// register indexes of the configuration port
	localparam logic [0:0] REG_ATTACK  = 1'b0;
	localparam logic [0:0] REG_RELEASE = 1'b1;

	typedef logic [16:0] weight_t;

	localparam weight_t     W_ONE       = 17'd65536;
	localparam weight_t     ATTACK_RST  = 17'd6554;
	localparam weight_t     RELEASE_RST = 17'd655;
	localparam logic [30:0] ONE_Q24     = 31'd16777216;
	localparam logic [30:0] ENV_MAX     = 31'h7FFF_FFFF;
	localparam logic [47:0] LMIN_Q40    = 48'd1100;
	localparam logic [47:0] POW_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam logic [33:0] STEP_CAP    = 34'h2_0000_0000;
	localparam logic signed [34:0] KMAX_Q30 = 35'sd1073741813;

	// round to nearest, ties away from zero; |x| < 2^63
	function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] x,
		input int s);
		logic [65:0] mag;
		logic [65:0] m;
		mag = x[65] ? (66'd0 - x) : x;
		m = (mag + (66'd1 << (s - 1))) >> s;
		return x[65] ? $signed(66'd0 - m) : $signed(m);
	endfunction

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (x < -66'sd2147483648)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

endpackage

// ===== src/lattice_adpcm_decoder.sv =====
// Lattice ADPCM decoder: envelope scaling, envelope tracking and GAL predictor.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, residual_value, restart | in
//  output   | out_valid, out_ready, sample_out          | out
//  config   | cfg_we, cfg_index, cfg_data               | in
//
// Each item passes a bit-serial square root and, per lattice stage, a
// bit-serial coefficient divider, which is skipped when the step saturates;
// the other steps share one 33x33 multiplier.
// in_ready is high only in the idle state; the result sits in an output
// register, so a new item is taken while it waits; the sequencer stalls at
// its final step only if the previous result has not been transferred yet.
// Reset (arst_n low) restores the weights and clears all predictor state.
module lattice_adpcm_decoder #(
	parameter int ORDER = lap_pkg::ORDER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   residual_value,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   sample_out,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  lap_pkg::weight_t     cfg_data
);
	import lap_pkg::*;

	localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_E0, ST_E1, ST_E2,
		ST_V0, ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_V6, ST_SQ,
		ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7,
		ST_DIV, ST_KU, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	weight_t attack_q, release_q;

	// model state
	logic [30:0]        env_q;
	logic signed [31:0] pred_q;
	logic signed [31:0] kc_q   [ORDER];
	logic [47:0]        pw_q   [ORDER];
	logic signed [31:0] bdel_q [ORDER+1];

	// working registers
	logic signed [31:0] res_q, ehat_q, xhat_q, sample_q;
	logic               out_valid_q;
	weight_t            w_q, w2_q;
	logic [62:0]        sq_q, sq2_q;
	logic [79:0]        acc_q;
	logic [63:0]        v2_q, x_q;
	logic [34:0]        rem_sq_q;
	logic [31:0]        root_q;
	logic [5:0]         cnt_q;
	logic [IW-1:0]      i_q;
	logic signed [31:0] fprev_q, bprev_q, f_q, b_q;
	logic [56:0]        sum_q;
	logic [47:0]        s_q, l_q, rem_q;
	logic signed [57:0] t_q;
	logic signed [56:0] g_q;
	logic [33:0]        nlow_q, quo_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	logic signed [31:0] k_cur, bd_cur;
	logic [47:0]        pw_cur;
	assign k_cur  = kc_q[i_q];
	assign bd_cur = bdel_q[i_q];
	assign pw_cur = pw_q[i_q];

	logic [32:0] em;
	assign em = ehat_q[31] ? (33'd0 - {1'b1, ehat_q}) : {1'b0, ehat_q};

	// operand selection per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_E0: begin mul_a = {res_q[31], res_q}; mul_b = {2'b0, env_q}; end
			ST_E2: begin mul_a = em; mul_b = em; end
			ST_V0: begin mul_a = {2'b0, env_q}; mul_b = {2'b0, env_q}; end
			ST_V1: begin mul_a = {1'b0, sq_q[62:31]}; mul_b = {16'b0, w_q}; end
			ST_V2: begin mul_a = {2'b0, sq_q[30:0]}; mul_b = {16'b0, w_q}; end
			ST_V3: begin mul_a = {1'b0, sq2_q[62:31]}; mul_b = {16'b0, w2_q}; end
			ST_V4: begin mul_a = {2'b0, sq2_q[30:0]}; mul_b = {16'b0, w2_q}; end
			ST_L0: begin mul_a = {k_cur[31], k_cur}; mul_b = {bd_cur[31], bd_cur}; end
			ST_L1: begin mul_a = {k_cur[31], k_cur}; mul_b = {fprev_q[31], fprev_q}; end
			ST_L2: begin mul_a = {fprev_q[31], fprev_q}; mul_b = {fprev_q[31], fprev_q}; end
			ST_L3: begin mul_a = {bd_cur[31], bd_cur}; mul_b = {bd_cur[31], bd_cur}; end
			ST_L4: begin mul_a = {f_q[31], f_q}; mul_b = {bd_cur[31], bd_cur}; end
			ST_L5: begin mul_a = {fprev_q[31], fprev_q}; mul_b = {b_q[31], b_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// rounded products
	logic signed [65:0] rnd8, rnd24, rnd30;
	assign rnd8  = rnd_shift(prod_q, 8);
	assign rnd24 = rnd_shift(prod_q, 24);
	assign rnd30 = rnd_shift(prod_q, 30);

	// square root digit step
	logic [34:0] sq_rem_n, sq_trial;
	logic        sq_ge;
	assign sq_rem_n = {rem_sq_q[32:0], x_q[63:62]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_rem_n >= sq_trial;

	// power estimate: 131*(P - s) by shift and add
	logic signed [48:0] pdiff;
	logic signed [57:0] pdx;
	assign pdiff = $signed({1'b0, pw_cur}) - $signed({1'b0, s_q});
	assign pdx   = {{9{pdiff[48]}}, pdiff};

	logic signed [65:0] lsum;
	logic [47:0]        lval;
	assign lsum = $signed({2'b0, s_q, 16'b0}) + {{8{t_q[57]}}, t_q} + 66'sd32768;
	assign lval = lsum[63:16];

	// gradient magnitude times the step size
	logic [56:0] gm;
	logic [63:0] gmx, num;
	assign gm  = g_q[56] ? (57'd0 - g_q) : g_q;
	assign gmx = {7'b0, gm};
	assign num = (gmx << 7) + (gmx << 1) + gmx;

	// divider step
	logic [48:0] div_r2;
	logic        div_ge;
	assign div_r2 = {rem_q, nlow_q[33]};
	assign div_ge = div_r2 >= {1'b0, l_q};

	// coefficient update
	logic [33:0]        stepv;
	logic signed [34:0] k35, knew;
	assign stepv = (quo_q > STEP_CAP) ? STEP_CAP : quo_q;
	assign k35   = {{3{k_cur[31]}}, k_cur};
	assign knew  = g_q[56] ? (k35 + $signed({1'b0, stepv})) : (k35 - $signed({1'b0, stepv}));

	logic [16:0] cfg_w;
	assign cfg_w = (cfg_data > W_ONE) ? W_ONE : cfg_data;

	logic last_stage;
	assign last_stage = (i_q == IW'(ORDER - 1));

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
			env_q       <= ONE_Q24;
			pred_q      <= '0;
			for (int j = 0; j < ORDER; j++) begin
				kc_q[j] <= '0;
				pw_q[j] <= '0;
			end
			for (int j = 0; j <= ORDER; j++) bdel_q[j] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ATTACK:  attack_q  <= cfg_w;
					REG_RELEASE: release_q <= cfg_w;
					default:     attack_q  <= attack_q;
				endcase
			end
			// output transfer; the final step refills the register itself
			if (out_valid_q && out_ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_q   <= residual_value;
						state_q <= ST_E0;
						if (restart) begin
							env_q  <= ONE_Q24;
							pred_q <= '0;
							for (int j = 0; j < ORDER; j++) begin
								kc_q[j] <= '0;
								pw_q[j] <= '0;
							end
							for (int j = 0; j <= ORDER; j++) bdel_q[j] <= '0;
						end
					end
				end
				ST_E0: state_q <= ST_E1;
				ST_E1: begin
					ehat_q  <= sat32(rnd24);
					state_q <= ST_E2;
				end
				ST_E2: begin
					xhat_q  <= sat32({{34{ehat_q[31]}}, ehat_q} + {{34{pred_q[31]}}, pred_q});
					fprev_q <= sat32({{34{ehat_q[31]}}, ehat_q} + {{34{pred_q[31]}}, pred_q});
					bprev_q <= sat32({{34{ehat_q[31]}}, ehat_q} + {{34{pred_q[31]}}, pred_q});
					w_q     <= (em > {2'b0, env_q}) ? attack_q : release_q;
					w2_q    <= W_ONE - ((em > {2'b0, env_q}) ? attack_q : release_q);
					state_q <= ST_V0;
				end
				// weighted mean of the squares
				ST_V0: begin
					sq_q    <= prod_q[62:0];
					state_q <= ST_V1;
				end
				ST_V1: begin
					sq2_q   <= prod_q[62:0];
					state_q <= ST_V2;
				end
				ST_V2: begin
					acc_q   <= {prod_q[48:0], 31'b0};
					state_q <= ST_V3;
				end
				ST_V3: begin
					acc_q   <= acc_q + {31'b0, prod_q[48:0]};
					state_q <= ST_V4;
				end
				ST_V4: begin
					v2_q    <= acc_q[79:16];
					acc_q   <= {prod_q[48:0], 31'b0};
					state_q <= ST_V5;
				end
				ST_V5: begin
					acc_q   <= acc_q + {31'b0, prod_q[48:0]};
					state_q <= ST_V6;
				end
				ST_V6: begin
					x_q      <= v2_q + acc_q[79:16];
					rem_sq_q <= '0;
					root_q   <= '0;
					cnt_q    <= 6'd31;
					state_q  <= ST_SQ;
				end
				// bit-serial square root, two radicand bits a cycle
				ST_SQ: begin
					rem_sq_q <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
					root_q   <= {root_q[30:0], sq_ge};
					x_q      <= {x_q[61:0], 2'b00};
					if (cnt_q == '0) begin
						if ({root_q[30:0], sq_ge} == 32'd0)
							env_q <= 31'd1;
						else if (root_q[30])
							env_q <= ENV_MAX;
						else
							env_q <= {root_q[29:0], sq_ge};
						i_q     <= '0;
						state_q <= ST_L0;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				// lattice stage
				ST_L0: state_q <= ST_L1;
				ST_L1: begin
					f_q     <= sat32({{34{fprev_q[31]}}, fprev_q} + rnd30);
					state_q <= ST_L2;
				end
				ST_L2: begin
					b_q     <= sat32({{34{bd_cur[31]}}, bd_cur} + rnd30);
					state_q <= ST_L3;
				end
				ST_L3: begin
					sum_q   <= {1'b0, prod_q[63:8]};
					state_q <= ST_L4;
				end
				ST_L4: begin
					if (sum_q + {1'b0, prod_q[63:8]} > {9'b0, POW_MAX})
						s_q <= POW_MAX;
					else
						s_q <= sum_q[47:0] + prod_q[55:8];
					state_q <= ST_L5;
				end
				ST_L5: begin
					g_q     <= rnd8[56:0];
					t_q     <= (pdx <<< 7) + (pdx <<< 1) + pdx;
					state_q <= ST_L6;
				end
				ST_L6: begin
					g_q     <= g_q + rnd8[56:0];
					l_q     <= (lval < LMIN_Q40) ? LMIN_Q40 : lval;
					state_q <= ST_L7;
				end
				ST_L7: begin
					pw_q[i_q] <= l_q;
					rem_q     <= {4'b0, num[63:20]};
					nlow_q    <= {num[19:0], 14'b0};
					cnt_q     <= 6'd33;
					if ({4'b0, num[63:20]} >= l_q) begin
						quo_q   <= STEP_CAP;
						state_q <= ST_KU;
					end else begin
						quo_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				// restoring divider, one quotient bit a cycle
				ST_DIV: begin
					rem_q  <= div_ge ? (div_r2[47:0] - l_q) : div_r2[47:0];
					quo_q  <= {quo_q[32:0], div_ge};
					nlow_q <= {nlow_q[32:0], 1'b0};
					if (cnt_q == '0)
						state_q <= ST_KU;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				ST_KU: begin
					if (knew > KMAX_Q30)
						kc_q[i_q] <= KMAX_Q30[31:0];
					else if (knew < -KMAX_Q30)
						kc_q[i_q] <= 32'(-KMAX_Q30);
					else
						kc_q[i_q] <= knew[31:0];
					bdel_q[i_q] <= bprev_q;
					fprev_q     <= f_q;
					bprev_q     <= b_q;
					if (last_stage) begin
						bdel_q[ORDER] <= b_q;
						pred_q  <= sat32({{34{xhat_q[31]}}, xhat_q} - {{34{f_q[31]}}, f_q});
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_L0;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						sample_q    <= xhat_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== test/lattice_adpcm_decoder_tb.sv =====
// Self-checking testbench of the lattice ADPCM decoder: predicts each sample and compares it.
`timescale 1ns / 1ps

module lattice_adpcm_decoder_tb;
	import lap_pkg::*;

	localparam int NLAT       = 8;
	localparam int ITEM_CYC   = 44 + 43 * NLAT;
	localparam int WDOG_LIMIT = 20 * ITEM_CYC;
	localparam int N_RANDOM   = 1000;

	// Sample predictor and queue of expected samples
	class sample_board;
		logic [63:0]     atk_w, rel_w;
		longint          env, pred;
		longint          coef [NLAT];
		logic [63:0]     spow [NLAT];
		longint          bdel [NLAT+1];
		logic [31:0]     exp_q [$];
		int              n_err;

		function new();
			atk_w = 64'd6554;
			rel_w = 64'd655;
			n_err = 0;
			clear();
		endfunction

		function void clear();
			env  = 64'sd16777216;
			pred = 0;
			foreach (coef[i]) coef[i] = 0;
			foreach (spow[i]) spow[i] = 0;
			foreach (bdel[i]) bdel[i] = 0;
		endfunction

		function void set_weight(logic [0:0] idx, logic [16:0] val);
			logic [63:0] w;
			w = (val > 17'd65536) ? 64'd65536 : 64'(val);
			if (idx == REG_ATTACK) atk_w = w;
			else rel_w = w;
		endfunction

		function logic [63:0] mag(longint x);
			return x < 0 ? 64'd0 - 64'(x) : 64'(x);
		endfunction

		function longint sat(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint rnd(longint x, int s);
			logic [63:0] m;
			m = (mag(x) + (64'd1 << (s - 1))) >> s;
			return x < 0 ? -longint'(m) : longint'(m);
		endfunction

		function logic [63:0] sqrt_trunc(logic [63:0] x);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [63:0] wmul(logic [63:0] x, logic [63:0] w);
			return (x >> 16) * w + (((x & 64'hFFFF) * w) >> 16);
		endfunction

		function logic [63:0] sq40(longint a);
			logic [63:0] m;
			m = mag(a);
			return (m * m) >> 8;
		endfunction

		// note an accepted input transfer and work out its sample
		function void note_input(logic signed [31:0] resid, logic rst);
			longint ehat, xhat, k, bd, g;
			logic [63:0] em, vm, w, v2, v, s, l, num, q, r, step;
			longint f [NLAT+1];
			longint b [NLAT+1];
			if (rst) clear();
			ehat = sat(rnd(longint'(resid) * env, 24));
			xhat = sat(ehat + pred);

			// envelope tracking
			em = mag(ehat);
			vm = 64'(env);
			w  = (em > vm) ? atk_w : rel_w;
			v2 = wmul(em * em, w) + wmul(vm * vm, 64'd65536 - w);
			v  = sqrt_trunc(v2);
			if (v < 1) v = 1;
			if (v > 64'd2147483647) v = 64'd2147483647;
			env = longint'(v);

			// lattice filter
			f[0] = xhat;
			b[0] = xhat;
			for (int m = 1; m <= NLAT; m++) begin
				f[m] = sat(f[m-1] + rnd(coef[m-1] * bdel[m-1], 30));
				b[m] = sat(bdel[m-1] + rnd(coef[m-1] * f[m-1], 30));
			end
			pred = sat(xhat - f[NLAT]);

			// coefficient adaptation
			for (int m = 1; m <= NLAT; m++) begin
				bd = bdel[m-1];
				s = sq40(f[m-1]) + sq40(bd);
				if (s > 64'hFFFF_FFFF_FFFF) s = 64'hFFFF_FFFF_FFFF;
				l = (64'd131 * spow[m-1] + 64'd65405 * s + 64'd32768) >> 16;
				if (l < 64'd1100) l = 64'd1100;
				spow[m-1] = l;
				g = rnd(f[m] * bd, 8) + rnd(f[m-1] * b[m], 8);
				num = mag(g) * 64'd131;
				q = num / l;
				r = num % l;
				if (q >= (64'd1 << 20)) step = 64'h2_0000_0000;
				else begin
					step = (q << 14) + ((r << 14) / l);
					if (step > 64'h2_0000_0000) step = 64'h2_0000_0000;
				end
				k = coef[m-1];
				k = (g < 0) ? k + longint'(step) : k - longint'(step);
				if (k > 64'sd1073741813) k = 64'sd1073741813;
				if (k < -64'sd1073741813) k = -64'sd1073741813;
				coef[m-1] = k;
			end
			for (int m = 0; m <= NLAT; m++) bdel[m] = b[m];
			exp_q.push_back(xhat[31:0]);
		endfunction

		// check one output transfer against the oldest expectation
		function void check_sample(logic [31:0] got);
			logic [31:0] want;
			if (exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected sample_out %h", got);
				return;
			end
			want = exp_q.pop_front();
			if (got !== want) begin
				n_err++;
				if (n_err <= 10)
					$display("sample_out mismatch: expected %h, actual %h", want, got);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic signed [31:0]  residual_value;
	logic                restart;
	logic                out_valid;
	logic                out_ready;
	logic signed [31:0]  sample_out;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	weight_t             cfg_data;

	sample_board board;
	int          burst_left;
	int          idle_cnt;
	int          stall_mode;
	int          mode_cnt;

	lattice_adpcm_decoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.residual_value(residual_value), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_input(residual_value, restart);
		if (arst_n && out_valid && out_ready) board.check_sample(sample_out);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt == WDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls in modes that change now and then
	always @(posedge clk) begin
		if (mode_cnt == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_cnt   <= $urandom_range(200, 3000);
		end else
			mode_cnt <= mode_cnt - 1;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic write_reg(logic [0:0] idx, weight_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		board.set_weight(idx, val);
		@(posedge clk);
	endtask

	task automatic set_weights(weight_t atk, weight_t rel);
		write_reg(REG_ATTACK, atk);
		write_reg(REG_RELEASE, rel);
		cfg_we <= 1'b0;
	endtask

	// one input transfer, with bursts and gaps between them
	task automatic send_item(logic signed [31:0] resid, logic rst);
		in_valid       <= 1'b1;
		residual_value <= resid;
		restart        <= rst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.exp_q.size() != 0) @(posedge clk);
		repeat (ITEM_CYC + 12) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_resid();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2, 3:    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			default: return $signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000;
		endcase
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_resid(), $urandom_range(0, 60) == 0);
	endtask

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		residual_value = '0;
		restart        = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_ATTACK;
		cfg_data       = '0;
		out_ready      = 1'b0;
		idle_cnt       = 0;
		stall_mode     = 0;
		mode_cnt       = 0;
		burst_left     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, restarts, saturation, reset weights
		send_item(32'sh0000_0000, 1'b0);
		send_item(32'sh0100_0000, 1'b0);
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh0000_0001, 1'b1);
		send_item(32'shFFFF_FFFF, 1'b0);
		for (int i = 0; i < 10; i++) send_item(32'sh0000_0000, 1'b0);
		send_item(32'shFF00_0000, 1'b1);
		send_item(32'sh00AA_5555, 1'b0);
		send_item(32'sh5555_AAAA, 1'b1);
		send_item(32'shAAAA_5555, 1'b0);
		drain();

		// weight settings, extremes first
		set_weights(17'd0, 17'd0);
		random_phase(150);
		drain();
		set_weights(W_ONE, W_ONE);
		random_phase(150);
		drain();
		set_weights(17'h1FFFF, 17'd0);
		random_phase(150);
		drain();
		set_weights(17'd0, 17'h1_0001);
		random_phase(100);
		drain();
		set_weights(ATTACK_RST, RELEASE_RST);
		random_phase(250);
		drain();
		set_weights(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
		random_phase(200);
		drain();

		if (board.n_err == 0 && board.exp_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
src/lap_pkg.sv
src/lattice_adpcm_decoder.sv
test/lattice_adpcm_decoder_tb.sv
